@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// A condition that must hold at every clock edge outside reset.
`define DTPC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define DTPC_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`else

`define DTPC_ASSERT_ALWAYS(lbl, cond, msg)
`define DTPC_ASSERT_NEXT(lbl, trig, cond, msg)

`endif

`endif

@@ design/dtpc_pkg.sv @@
// ---------------------------------------------------------------------------
// Digit trie prefix check package
// Sizes, transaction types and helper functions shared by the block.
// ---------------------------------------------------------------------------
package dtpc_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int MAX_DIGITS = 9;
  localparam int RADIX      = 10;

  localparam int DIGIT_W    = 4;
  localparam int DIGITS_W   = 36;
  localparam int LEN_W      = 4;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = NODE_W + 1;
  localparam int LINK_DEPTH = NODE_COUNT * RADIX;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);

  // Transaction kinds carried in the kind field.
  localparam logic KIND_NEW_SET = 1'b0;
  localparam logic KIND_INSERT  = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [DIGITS_W-1:0] digits;
    logic [LEN_W-1:0]    length;
  } in_item_t;

  typedef struct packed {
    logic number_conflict;
    logic set_conflict;
    logic store_full;
    logic bad_digit;
  } out_item_t;

  // Per-node record written when the node is allocated.
  typedef struct packed {
    logic               end_mark;
    logic [NODE_W-1:0]  parent;
    logic [DIGIT_W-1:0] digit;
  } node_info_t;

  typedef struct packed {
    logic               en;
    logic [LINK_AW-1:0] addr;
    logic [NODE_W-1:0]  data;
  } link_wr_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    node_info_t        data;
  } info_wr_t;

  // Digit at a position of the stored number; positions past the end read as zero.
  function automatic logic [DIGIT_W-1:0] digit_at(input logic [DIGITS_W-1:0] d,
                                                  input logic [LEN_W-1:0]    idx);
    logic [DIGIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (idx == LEN_W'(i)) begin
        r = d[DIGIT_W*i +: DIGIT_W];
      end
    end
    return r;
  endfunction

  // Address of the child link of a node for one digit.
  function automatic logic [LINK_AW-1:0] link_addr(input logic [NODE_W-1:0]  node,
                                                   input logic [DIGIT_W-1:0] digit);
    logic [LINK_AW-1:0] a;
    a = LINK_AW'(node) * LINK_AW'(RADIX) + LINK_AW'(digit);
    return a;
  endfunction

endpackage

@@ design/digit_trie_prefix_check.sv @@
// ---------------------------------------------------------------------------
// Digit trie prefix check
// Builds a decimal digit trie in a fixed node pool and reports, for each
// inserted number, whether it breaks the prefix-free property of its set.
// ---------------------------------------------------------------------------
// The block takes one transaction at a time and returns exactly one result
// transaction for each. After reset it first runs a clearing pass over all
// NODE_COUNT * RADIX entries (10240 at the default sizes) of the child
// link memory, one entry per cycle; no input is taken during that pass. A
// new-set transaction, a number with a bad digit, a zero length or any
// number arriving after the set is already in conflict goes from accept
// straight to the result step. An insert steps through accept, the start
// and first states that prime the link memory, one walk step per link on
// the path (the last of these finds the link missing or the conflict), one
// allocation step per new node and the result step that hands it over.
// The walk is set by the single read port of the link memory: each cycle
// reads the next link speculatively while the record of the candidate node
// is checked. A finished result sits in an output register, so the next
// transaction may be accepted while it waits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module digit_trie_prefix_check
  import dtpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_START  = 3'd2;
  localparam logic [2:0] ST_FIRST  = 3'd3;
  localparam logic [2:0] ST_WALK   = 3'd4;
  localparam logic [2:0] ST_ALLOC  = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [LINK_AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [DIGITS_W-1:0] digits_r, digits_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    depth_r, depth_nxt;
  logic [NODE_W-1:0]   node_r, node_nxt;
  logic [NODE_W-1:0]   cand_r, cand_nxt;
  logic [FREE_W-1:0]   next_free_r, next_free_nxt;
  logic                conflict_seen_r, conflict_seen_nxt;
  out_item_t           res_r, res_nxt;
  logic                out_valid_r;
  out_item_t           out_item_r;
  logic                out_load;

  // Node store interface.
  logic [LINK_AW-1:0]  link_raddr;
  logic [NODE_W-1:0]   link_rdata;
  link_wr_t            link_wr;
  logic [NODE_W-1:0]   info_raddr;
  node_info_t          info_rdata;
  info_wr_t            info_wr;

  // Input decode.
  logic [LEN_W-1:0]    len_sat;
  logic [DIGITS_W-1:0] digits_masked;
  logic                in_bad;

  // Walk and allocation helpers.
  logic [DIGIT_W-1:0]  cur_digit;
  logic                step_last;
  logic                cand_ok;
  logic [FREE_W-1:0]   free_cnt;
  logic [FREE_W-1:0]   need_cnt;

  dtpc_node_store u_store (
    .clk        (clk),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata),
    .link_wr    (link_wr),
    .info_raddr (info_raddr),
    .info_rdata (info_rdata),
    .info_wr    (info_wr)
  );

  // Saturate the length, zero the unused nibbles and look for a digit that
  // is out of range among the used ones.
  always_comb begin
    len_sat = (in_item.length > LEN_W'(MAX_DIGITS)) ? LEN_W'(MAX_DIGITS) : in_item.length;
    digits_masked = '0;
    in_bad = 1'b0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (LEN_W'(i) < len_sat) begin
        digits_masked[DIGIT_W*i +: DIGIT_W] = in_item.digits[DIGIT_W*i +: DIGIT_W];
        if ({1'b0, in_item.digits[DIGIT_W*i +: DIGIT_W]} >= (DIGIT_W + 1)'(RADIX)) begin
          in_bad = 1'b1;
        end
      end
    end
  end

  assign cur_digit = digit_at(digits_r, depth_r);
  assign step_last = ((depth_r + LEN_W'(1)) == len_r);
  assign free_cnt  = FREE_W'(NODE_COUNT) - next_free_r;
  assign need_cnt  = FREE_W'(len_r - depth_r);

  // The memories are never cleared on a new set. A link is trusted only if
  // it names a node allocated in the current set whose own record says it
  // hangs off the present node under the present digit; a stale link from an
  // earlier set fails one of those tests. The root is never a child, so a
  // link of zero means no child. As the allocation test gates the others, the
  // record of a node not yet allocated never decides the result.
  assign cand_ok = (cand_r != '0) &&
                   (FREE_W'(cand_r) < next_free_r) &&
                   (info_rdata.parent == node_r) &&
                   (info_rdata.digit == cur_digit);

  always_comb begin
    state_nxt         = state_r;
    clr_addr_nxt      = clr_addr_r;
    digits_nxt        = digits_r;
    len_nxt           = len_r;
    depth_nxt         = depth_r;
    node_nxt          = node_r;
    cand_nxt          = cand_r;
    next_free_nxt     = next_free_r;
    conflict_seen_nxt = conflict_seen_r;
    res_nxt           = res_r;
    out_load          = 1'b0;
    link_raddr        = link_addr(node_r, cur_digit);
    info_raddr        = link_rdata;
    link_wr           = '0;
    info_wr           = '0;

    unique case (state_r)
      ST_CLEAR: begin
        // Post-reset sweep so that every link reads as a defined value.
        link_wr.en   = 1'b1;
        link_wr.addr = clr_addr_r;
        link_wr.data = '0;
        clr_addr_nxt = clr_addr_r + LINK_AW'(1);
        if (clr_addr_r == LINK_AW'(LINK_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          digits_nxt = digits_masked;
          len_nxt    = len_sat;
          depth_nxt  = '0;
          node_nxt   = '0;
          res_nxt    = '0;
          if (in_item.kind == KIND_NEW_SET) begin
            // New set: the pool and the sticky flag start afresh.
            next_free_nxt     = FREE_W'(1);
            conflict_seen_nxt = 1'b0;
            state_nxt         = ST_RESULT;
          end else if (in_bad) begin
            res_nxt.set_conflict = conflict_seen_r;
            res_nxt.bad_digit    = 1'b1;
            state_nxt            = ST_RESULT;
          end else if ((len_sat == '0) || conflict_seen_r) begin
            res_nxt.set_conflict = conflict_seen_r;
            state_nxt            = ST_RESULT;
          end else begin
            state_nxt = ST_START;
          end
        end
      end

      ST_START: begin
        // The default read address fetches the root's link for the first digit.
        state_nxt = ST_FIRST;
      end

      ST_FIRST: begin
        cand_nxt   = link_rdata;
        link_raddr = link_addr(link_rdata, digit_at(digits_r, depth_r + LEN_W'(1)));
        state_nxt  = ST_WALK;
      end

      ST_WALK: begin
        if (cand_ok) begin
          if (info_rdata.end_mark || step_last) begin
            conflict_seen_nxt       = 1'b1;
            res_nxt.number_conflict = 1'b1;
            res_nxt.set_conflict    = 1'b1;
            state_nxt               = ST_RESULT;
          end else begin
            // Step down; the link read in flight belongs to the new node.
            node_nxt   = cand_r;
            depth_nxt  = depth_r + LEN_W'(1);
            cand_nxt   = link_rdata;
            link_raddr = link_addr(link_rdata, digit_at(digits_r, depth_r + LEN_W'(2)));
          end
        end else if (free_cnt < need_cnt) begin
          res_nxt.set_conflict = conflict_seen_r;
          res_nxt.store_full   = 1'b1;
          state_nxt            = ST_RESULT;
        end else begin
          state_nxt = ST_ALLOC;
        end
      end

      ST_ALLOC: begin
        link_wr.en             = 1'b1;
        link_wr.addr           = link_addr(node_r, cur_digit);
        link_wr.data           = next_free_r[NODE_W-1:0];
        info_wr.en             = 1'b1;
        info_wr.addr           = next_free_r[NODE_W-1:0];
        info_wr.data.end_mark  = step_last;
        info_wr.data.parent    = node_r;
        info_wr.data.digit     = cur_digit;
        node_nxt               = next_free_r[NODE_W-1:0];
        next_free_nxt          = next_free_r + FREE_W'(1);
        depth_nxt              = depth_r + LEN_W'(1);
        if (step_last) begin
          res_nxt.set_conflict = conflict_seen_r;
          state_nxt            = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      clr_addr_r      <= '0;
      next_free_r     <= FREE_W'(1);
      conflict_seen_r <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      clr_addr_r      <= clr_addr_nxt;
      next_free_r     <= next_free_nxt;
      conflict_seen_r <= conflict_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r <= digits_nxt;
    len_r    <= len_nxt;
    depth_r  <= depth_nxt;
    node_r   <= node_nxt;
    cand_r   <= cand_nxt;
    res_r    <= res_nxt;
  end

  // Output register: holds a finished result until the far side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= res_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The allocation pointer never runs past the end of the pool.
  `DTPC_ASSERT_ALWAYS(a_free_in_range, next_free_r <= FREE_W'(NODE_COUNT), "node pool overrun")

  // Every allocation cycle consumes exactly one node.
  `DTPC_ASSERT_NEXT(a_alloc_step, state_r == ST_ALLOC,
                    next_free_r == $past(next_free_r) + FREE_W'(1),
                    "allocation did not advance the pool")

  // A result that reaches the output register is presented in the next cycle.
  `DTPC_ASSERT_NEXT(a_result_loaded, out_load,
                    out_valid_r && (out_item_r == $past(res_r)),
                    "result not loaded")

  // A number conflict always shows in the sticky set flag too.
  `DTPC_ASSERT_ALWAYS(a_conflict_sticky,
                      !out_valid_r || !out_item_r.number_conflict || out_item_r.set_conflict,
                      "number conflict without set conflict")

endmodule

@@ design/dtpc_node_store.sv @@
// ---------------------------------------------------------------------------
// Digit trie node store
// Child link memory and per-node record memory, each with one write port
// and one registered read port.
// ---------------------------------------------------------------------------
module dtpc_node_store
  import dtpc_pkg::*;
(
  input  logic               clk,
  input  logic [LINK_AW-1:0] link_raddr,
  output logic [NODE_W-1:0]  link_rdata,
  input  link_wr_t           link_wr,
  input  logic [NODE_W-1:0]  info_raddr,
  output node_info_t         info_rdata,
  input  info_wr_t           info_wr
);

  logic [NODE_W-1:0] link_mem [LINK_DEPTH];
  node_info_t        info_mem [NODE_COUNT];

  logic [NODE_W-1:0] link_rdata_r;
  node_info_t        info_rdata_r;

  always_ff @(posedge clk) begin
    if (link_wr.en) begin
      link_mem[link_wr.addr] <= link_wr.data;
    end
    link_rdata_r <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (info_wr.en) begin
      info_mem[info_wr.addr] <= info_wr.data;
    end
    info_rdata_r <= info_mem[info_raddr];
  end

  assign link_rdata = link_rdata_r;
  assign info_rdata = info_rdata_r;

endmodule
